[rtl/pws_pkg.sv]
// Shared types and constants for the phase window statistics block.
// Used by pws_mean_div and phase_window_statistics; no dependencies.

package pws_pkg;

   localparam int RAW_W       = 32;
   localparam int TICK_W      = 24;
   localparam int SCALE_W     = 4;
   localparam int PH_W        = 28;
   localparam int SUM_W       = 34;
   localparam int NUM_W       = 32;
   localparam int CSR_INDEX_W = 1;
   localparam int CSR_DATA_W  = 24;

   localparam int WINDOW_DEFAULT = 10;

   localparam logic [TICK_W-1:0]  MAX_TICKS_RESET = TICK_W'(625000);
   localparam logic [SCALE_W-1:0] NS_PER_TICK_RESET = SCALE_W'(8);

   localparam logic [PH_W-1:0] PH_MAX = {1'b0, {(PH_W-1){1'b1}}};
   localparam logic [PH_W-1:0] PH_MIN = {1'b1, {(PH_W-1){1'b0}}};

   typedef enum logic [CSR_INDEX_W-1:0] {
      REG_TICK_LIMIT  = 1'b0,
      REG_NS_PER_TICK = 1'b1
   } csr_reg_type;

   // Window summary fields that travel alongside the mean computation.
   typedef struct packed {
      logic [NUM_W-1:0] summary_number;
      logic [PH_W-1:0]  min_ns;
      logic [PH_W-1:0]  max_ns;
      logic [PH_W-1:0]  p2p_ns;
   } pws_side_type;

endpackage

[rtl/pws_mean_div.sv]
// Pipelined window mean: divides the window sum by WINDOW (toward zero) with a
// reciprocal multiply and one correction step. Depends on pws_pkg.

module pws_mean_div #(
   parameter int WINDOW = pws_pkg::WINDOW_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          in_valid,
   output logic                          in_ready,
   input  logic [pws_pkg::SUM_W-1:0]     in_sum,
   input  pws_pkg::pws_side_type         in_side,
   output logic                          out_valid,
   input  logic                          out_stall,
   output logic [pws_pkg::PH_W-1:0]      out_avg,
   output pws_pkg::pws_side_type         out_side
);

   localparam int STAGES = 7;
   localparam int SW     = pws_pkg::SUM_W;
   localparam int PW     = pws_pkg::PH_W;
   localparam int PROD_W = 2 * SW;
   localparam int H      = SW / 2;
   localparam logic [PROD_W-1:0] SCALE_ONE = PROD_W'(1) << SW;
   localparam logic [SW-1:0]     RECIP     = SW'(SCALE_ONE / PROD_W'(WINDOW));
   localparam logic [SW-1:0]     DIVISOR   = SW'(WINDOW);

   logic [STAGES:1] valid_ff;
   logic [STAGES:1] prev_valid;
   logic [STAGES:1] ready;

   // stage payloads
   logic [SW-1:0]          sum1_ff;
   pws_pkg::pws_side_type  side1_ff, side2_ff, side3_ff, side4_ff, side5_ff, side6_ff, side7_ff;
   pws_pkg::pws_side_type  side2_in;
   logic                   neg2_ff, neg3_ff, neg4_ff, neg5_ff, neg6_ff;
   logic [SW-1:0]          mag2_ff, mag3_ff, mag4_ff, mag5_ff;
   logic [SW-1:0]          mag2_in;
   logic [SW-1:0]          pp_ll3_ff, pp_lh3_ff, pp_hl3_ff, pp_hh3_ff;
   logic [SW-1:0]          pp_ll3_in, pp_lh3_in, pp_hl3_in, pp_hh3_in;
   logic [PROD_W-1:0]      full_prod;
   logic [PW-1:0]          qest4_ff, qest5_ff;
   logic [SW-1:0]          prod5_ff, prod5_in;
   logic [SW-1:0]          rem5;
   logic [PW-1:0]          q6_ff, q6_in;
   logic [PW-1:0]          avg7_ff;

   always_comb begin
      ready[STAGES] = !valid_ff[STAGES] || !out_stall;
      for (int k = STAGES - 1; k >= 1; k--) begin
         ready[k] = !valid_ff[k] || ready[k+1];
      end
   end

   assign prev_valid = {valid_ff[STAGES-1:1], in_valid};
   assign in_ready   = ready[1];

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         for (int k = 1; k <= STAGES; k++) begin
            if (ready[k]) begin
               valid_ff[k] <= prev_valid[k];
            end
         end
      end
   end

   // stage 2: magnitude, sign, peak-to-peak
   always_comb begin
      mag2_in         = sum1_ff[SW-1] ? (~sum1_ff + SW'(1)) : sum1_ff;
      side2_in        = side1_ff;
      side2_in.p2p_ns = side1_ff.max_ns - side1_ff.min_ns;
   end

   // stage 3: partial products of magnitude times reciprocal
   assign pp_ll3_in = SW'(mag2_ff[H-1:0])  * SW'(RECIP[H-1:0]);
   assign pp_lh3_in = SW'(mag2_ff[H-1:0])  * SW'(RECIP[SW-1:H]);
   assign pp_hl3_in = SW'(mag2_ff[SW-1:H]) * SW'(RECIP[H-1:0]);
   assign pp_hh3_in = SW'(mag2_ff[SW-1:H]) * SW'(RECIP[SW-1:H]);

   // stage 4: quotient estimate, low by at most one
   assign full_prod = PROD_W'(pp_ll3_ff) + (PROD_W'(pp_lh3_ff) << H)
                    + (PROD_W'(pp_hl3_ff) << H) + (PROD_W'(pp_hh3_ff) << (2 * H));

   // stage 5: back-multiply
   assign prod5_in = SW'(qest4_ff) * DIVISOR;

   // stage 6: correction
   assign rem5  = mag5_ff - prod5_ff;
   assign q6_in = qest5_ff + PW'(rem5 >= DIVISOR);

   always_ff @(posedge clock) begin
      if (ready[1]) begin
         sum1_ff  <= in_sum;
         side1_ff <= in_side;
      end
      if (ready[2]) begin
         neg2_ff  <= sum1_ff[SW-1];
         mag2_ff  <= mag2_in;
         side2_ff <= side2_in;
      end
      if (ready[3]) begin
         neg3_ff   <= neg2_ff;
         mag3_ff   <= mag2_ff;
         pp_ll3_ff <= pp_ll3_in;
         pp_lh3_ff <= pp_lh3_in;
         pp_hl3_ff <= pp_hl3_in;
         pp_hh3_ff <= pp_hh3_in;
         side3_ff  <= side2_ff;
      end
      if (ready[4]) begin
         neg4_ff  <= neg3_ff;
         mag4_ff  <= mag3_ff;
         qest4_ff <= full_prod[SW+PW-1:SW];
         side4_ff <= side3_ff;
      end
      if (ready[5]) begin
         neg5_ff  <= neg4_ff;
         mag5_ff  <= mag4_ff;
         qest5_ff <= qest4_ff;
         prod5_ff <= prod5_in;
         side5_ff <= side4_ff;
      end
      if (ready[6]) begin
         neg6_ff  <= neg5_ff;
         q6_ff    <= q6_in;
         side6_ff <= side5_ff;
      end
      if (ready[7]) begin
         avg7_ff  <= neg6_ff ? (~q6_ff + PW'(1)) : q6_ff;
         side7_ff <= side6_ff;
      end
   end

   assign out_valid = valid_ff[STAGES];
   assign out_avg   = avg7_ff;
   assign out_side  = side7_ff;

`ifndef NO_ASSERTIONS
   a_estimate_close: assert property (@(posedge clock) disable iff (reset)
      valid_ff[5] |-> (mag5_ff >= prod5_ff) && (rem5 < SW'(2 * WINDOW)))
      else $error("quotient estimate off by more than one");

   a_mean_in_range: assert property (@(posedge clock) disable iff (reset)
      valid_ff[STAGES] |-> ($signed(avg7_ff) >= $signed(side7_ff.min_ns))
                        && ($signed(avg7_ff) <= $signed(side7_ff.max_ns)))
      else $error("window mean outside min/max");

   a_out_hold: assert property (@(posedge clock) disable iff (reset)
      (valid_ff[STAGES] && out_stall) |=> valid_ff[STAGES] && $stable(avg7_ff)
                                          && $stable(side7_ff))
      else $error("stalled summary beat changed");
`endif

endmodule

[rtl/phase_window_statistics.sv]
// Top level of the phase window statistics block: registers, phase scaling,
// window accumulators and summary counter. Depends on pws_pkg, pws_mean_div.

// Takes one measurement beat per cycle. A present forward count below the
// tick limit becomes a positive phase in ns; otherwise a present reverse count
// below it becomes a negative one. Every WINDOW phases give one summary beat
// (mean toward zero, min, max, peak-to-peak, summary number). rsp_valid rises
// once the beat that closes the window has been accepted and has passed the phase
// register, then a 7-stage reciprocal divider whose last stage is the output
// register. Input stalls only when a window closes while that divider is
// backed up by rsp_stall. Write registers only while no summary is in flight.

module phase_window_statistics #(
   parameter int WINDOW = pws_pkg::WINDOW_DEFAULT
) (
   input  logic                                 clock,
   input  logic                                 reset,

   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic                                 req_fwd_present,
   input  logic [pws_pkg::RAW_W-1:0]            req_fwd_raw,
   input  logic                                 req_rev_present,
   input  logic [pws_pkg::RAW_W-1:0]            req_rev_raw,

   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic [pws_pkg::NUM_W-1:0]            rsp_summary_number,
   output logic signed [pws_pkg::PH_W-1:0]      rsp_avg_ns,
   output logic signed [pws_pkg::PH_W-1:0]      rsp_min_ns,
   output logic signed [pws_pkg::PH_W-1:0]      rsp_max_ns,
   output logic [pws_pkg::PH_W-1:0]             rsp_p2p_ns,

   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [pws_pkg::CSR_INDEX_W-1:0]      csr_index,
   input  logic [pws_pkg::CSR_DATA_W-1:0]       csr_data
);

   localparam int CNT_W = $clog2(WINDOW);
   localparam int PW    = pws_pkg::PH_W;
   localparam int SW    = pws_pkg::SUM_W;
   localparam int RW    = pws_pkg::RAW_W;
   localparam int TW    = pws_pkg::TICK_W;
   localparam logic [PW-1:0] NEG_LIMIT = {1'b1, {(PW-1){1'b0}}};

   logic [TW-1:0]                 max_ticks_ff;
   logic [pws_pkg::SCALE_W-1:0]   ns_per_tick_ff;

   logic [RW-1:0]   fwd_ticks, rev_ticks;
   logic            fwd_ok, rev_ok, got;
   logic [TW-1:0]   sel_ticks;
   logic [PW-1:0]   mag, pos_phase, neg_phase, phase_in;

   logic            ph_valid_ff;
   logic [PW-1:0]   ph_ff;
   logic            ph_ready, ph_take;

   logic [CNT_W-1:0]            count_ff;
   logic [SW-1:0]               sum_ff, sum_in;
   logic [PW-1:0]               min_ff, min_in, max_ff, max_in;
   logic [pws_pkg::NUM_W-1:0]   summary_ff;
   logic                        last_sample;

   logic                        div_in_valid, div_in_ready;
   pws_pkg::pws_side_type       div_in_side, div_out_side;
   logic [PW-1:0]               div_out_avg;

   // configuration
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         max_ticks_ff   <= pws_pkg::MAX_TICKS_RESET;
         ns_per_tick_ff <= pws_pkg::NS_PER_TICK_RESET;
      end else if (csr_valid && csr_ready) begin
         case (pws_pkg::csr_reg_type'(csr_index))
            pws_pkg::REG_TICK_LIMIT:  max_ticks_ff <= csr_data[TW-1:0];
            pws_pkg::REG_NS_PER_TICK: ns_per_tick_ff <= csr_data[pws_pkg::SCALE_W-1:0];
            default: ;
         endcase
      end
   end

   // phase scaling; forward wins when both are in range
   always_comb begin
      fwd_ticks = ~req_fwd_raw;
      rev_ticks = ~req_rev_raw;
      fwd_ok    = req_fwd_present && (fwd_ticks < RW'(max_ticks_ff));
      rev_ok    = req_rev_present && (rev_ticks < RW'(max_ticks_ff));
      got       = fwd_ok || rev_ok;
      sel_ticks = fwd_ok ? fwd_ticks[TW-1:0] : rev_ticks[TW-1:0];
      mag       = PW'(sel_ticks) * PW'(ns_per_tick_ff);
      pos_phase = mag[PW-1] ? pws_pkg::PH_MAX : mag;
      neg_phase = (mag > NEG_LIMIT) ? pws_pkg::PH_MIN : (~mag + PW'(1));
      phase_in  = fwd_ok ? pos_phase : neg_phase;
   end

   assign ph_ready  = !ph_valid_ff || ph_take;
   assign req_stall = !ph_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         ph_valid_ff <= 1'b0;
      end else if (ph_ready) begin
         ph_valid_ff <= req_valid && got;
      end
   end

   always_ff @(posedge clock) begin
      if (ph_ready) begin
         ph_ff <= phase_in;
      end
   end

   // window accumulators
   always_comb begin
      last_sample  = (count_ff == CNT_W'(WINDOW - 1));
      ph_take      = ph_valid_ff && (!last_sample || div_in_ready);
      div_in_valid = ph_valid_ff && last_sample;
      sum_in       = sum_ff + {{(SW-PW){ph_ff[PW-1]}}, ph_ff};
      min_in       = ($signed(ph_ff) < $signed(min_ff)) ? ph_ff : min_ff;
      max_in       = ($signed(ph_ff) > $signed(max_ff)) ? ph_ff : max_ff;
      div_in_side.summary_number = summary_ff;
      div_in_side.min_ns         = min_in;
      div_in_side.max_ns         = max_in;
      div_in_side.p2p_ns         = '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff   <= '0;
         sum_ff     <= '0;
         min_ff     <= pws_pkg::PH_MAX;
         max_ff     <= pws_pkg::PH_MIN;
         summary_ff <= '0;
      end else if (ph_take) begin
         if (last_sample) begin
            count_ff   <= '0;
            sum_ff     <= '0;
            min_ff     <= pws_pkg::PH_MAX;
            max_ff     <= pws_pkg::PH_MIN;
            summary_ff <= summary_ff + pws_pkg::NUM_W'(1);
         end else begin
            count_ff <= count_ff + CNT_W'(1);
            sum_ff   <= sum_in;
            min_ff   <= min_in;
            max_ff   <= max_in;
         end
      end
   end

   pws_mean_div #(
      .WINDOW (WINDOW)
   ) u_mean_div (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (div_in_valid),
      .in_ready  (div_in_ready),
      .in_sum    (sum_in),
      .in_side   (div_in_side),
      .out_valid (rsp_valid),
      .out_stall (rsp_stall),
      .out_avg   (div_out_avg),
      .out_side  (div_out_side)
   );

   assign rsp_summary_number  = div_out_side.summary_number;
   assign rsp_avg_ns          = div_out_avg;
   assign rsp_min_ns          = div_out_side.min_ns;
   assign rsp_max_ns          = div_out_side.max_ns;
   assign rsp_p2p_ns          = div_out_side.p2p_ns;

`ifndef NO_ASSERTIONS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      32'(count_ff) < WINDOW)
      else $error("sample count reached window size");

   a_summary_step: assert property (@(posedge clock) disable iff (reset)
      (div_in_valid && div_in_ready) |=> summary_ff == $past(summary_ff) + pws_pkg::NUM_W'(1))
      else $error("summary number did not advance with a summary beat");

   a_window_order: assert property (@(posedge clock) disable iff (reset)
      (count_ff != '0) |-> ($signed(min_ff) <= $signed(max_ff)))
      else $error("window minimum above maximum");
`endif

endmodule

[verif/testbench.sv]
// Self-checking testbench for phase_window_statistics: random and directed measurement
// beats, register sweeps, window summaries compared against an in-bench predictor.
// Depends on pws_pkg and the phase_window_statistics RTL.

module testbench;

   localparam int     WIN          = 10;
   localparam longint PHASE_TOP    = 134217727;
   localparam longint PHASE_BOTTOM = -134217728;

   typedef struct packed {
      logic        fwd_present;
      logic [31:0] fwd_raw;
      logic        rev_present;
      logic [31:0] rev_raw;
   } meas_type;

   typedef struct {
      logic [31:0]        number;
      logic signed [27:0] avg;
      logic signed [27:0] lo;
      logic signed [27:0] hi;
      logic [27:0]        spread;
   } summary_type;

   typedef enum {FLOW, LIGHT, HEAVY, PERIODIC} stall_style_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic        req_valid = 1'b0;
   logic        req_stall;
   meas_type    on_bus = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [31:0] rsp_summary_number;
   logic signed [27:0] rsp_avg_ns;
   logic signed [27:0] rsp_min_ns;
   logic signed [27:0] rsp_max_ns;
   logic [27:0] rsp_p2p_ns;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   pws_pkg::csr_reg_type csr_index = pws_pkg::REG_TICK_LIMIT;
   logic [23:0] csr_data = '0;

   // register mirror and window state
   logic [23:0] cfg_max_ticks = 24'd625000;
   logic [3:0]  cfg_ns = 4'd8;
   int          win_count = 0;
   longint      win_sum = 0;
   longint      win_min = PHASE_TOP;
   longint      win_max = PHASE_BOTTOM;
   logic [31:0] summaries_made = '0;

   meas_type    pending_meas[$];
   summary_type expected_summaries[$];

   int errors = 0;
   int beats_sent = 0;
   int samples_taken = 0;
   int summaries_checked = 0;
   int settings_used = 0;
   int burst_left = 0;
   int gap_left = 0;
   int stall_left = 0;
   stall_style_type stall_style = FLOW;

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   phase_window_statistics #(.WINDOW(WIN)) u_dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_fwd_present     (on_bus.fwd_present),
      .req_fwd_raw         (on_bus.fwd_raw),
      .req_rev_present     (on_bus.rev_present),
      .req_rev_raw         (on_bus.rev_raw),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_summary_number  (rsp_summary_number),
      .rsp_avg_ns          (rsp_avg_ns),
      .rsp_min_ns          (rsp_min_ns),
      .rsp_max_ns          (rsp_max_ns),
      .rsp_p2p_ns          (rsp_p2p_ns),
      .csr_valid           (csr_valid),
      .csr_ready           (csr_ready),
      .csr_index           (csr_index),
      .csr_data            (csr_data)
   );

   function automatic bit scaled_ticks(input logic [31:0] raw, output longint mag);
      logic [31:0] ticks;
      ticks = ~raw;
      mag = longint'(ticks) * longint'(cfg_ns);
      return ticks < {8'd0, cfg_max_ticks};
   endfunction

   function automatic bit takes_sample(input meas_type m);
      longint mag;
      return (m.fwd_present && scaled_ticks(m.fwd_raw, mag)) ||
             (m.rev_present && scaled_ticks(m.rev_raw, mag));
   endfunction

   // forward wins; reverse only when forward gave nothing
   function automatic void account_measurement(input meas_type m);
      longint      mag;
      longint      ph;
      bit          hit;
      summary_type s;
      hit = 1'b0;
      ph = 0;
      if (m.fwd_present && scaled_ticks(m.fwd_raw, mag)) begin
         ph = (mag > PHASE_TOP) ? PHASE_TOP : mag;
         hit = 1'b1;
      end
      if (!hit && m.rev_present && scaled_ticks(m.rev_raw, mag)) begin
         ph = (mag > 134217728) ? PHASE_BOTTOM : -mag;
         hit = 1'b1;
      end
      if (!hit) return;
      samples_taken++;
      win_sum += ph;
      if (ph < win_min) win_min = ph;
      if (ph > win_max) win_max = ph;
      win_count++;
      if (win_count == WIN) begin
         s.number = summaries_made;
         s.avg    = 28'(win_sum / WIN);
         s.lo     = 28'(win_min);
         s.hi     = 28'(win_max);
         s.spread = 28'(win_max - win_min);
         expected_summaries.push_back(s);
         summaries_made++;
         win_count = 0;
         win_sum = 0;
         win_min = PHASE_TOP;
         win_max = PHASE_BOTTOM;
      end
   endfunction

   function automatic void compare(input string what, input logic signed [63:0] want,
                                   input logic signed [63:0] got);
      if (want !== got) begin
         errors++;
         if (errors <= 40)
            $display("%0t: %s mismatch, expected %0d actual %0d", $time, what, want, got);
      end
   endfunction

   function automatic meas_type beat(input bit fp, input logic [31:0] ft,
                                     input bit rp, input logic [31:0] rt);
      return '{fp, ~ft, rp, ~rt};
   endfunction

   function automatic logic [31:0] pick_ticks();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 50) return (cfg_max_ticks == 0) ? 32'd0 : 32'($urandom_range(0, cfg_max_ticks - 1));
      if (r < 70) return {8'd0, cfg_max_ticks} + $urandom_range(0, 4) - 2;
      if (r < 85) return $urandom_range(0, 3);
      return $urandom;
   endfunction

   function automatic meas_type random_measurement();
      meas_type m;
      int unsigned r;
      r = $urandom_range(0, 99);
      m.fwd_present = 1'b1;
      m.fwd_raw     = ~pick_ticks();
      m.rev_present = 1'($urandom_range(0, 1));
      m.rev_raw     = ~pick_ticks();
      if (r >= 60 && r < 85) begin
         // forward out of range, reverse carries the sample
         m.fwd_present = 1'($urandom_range(0, 1));
         m.fwd_raw     = ~({8'd0, cfg_max_ticks} + $urandom_range(0, 1000));
         m.rev_present = 1'b1;
      end else if (r >= 85) begin
         m = {1'($urandom_range(0, 1)), $urandom, 1'($urandom_range(0, 1)), $urandom};
      end
      return m;
   endfunction

   task automatic load_random(input int target, input int cap);
      meas_type m;
      int       taken;
      int       made;
      taken = 0;
      made = 0;
      while (taken < target && made < cap) begin
         m = random_measurement();
         if (takes_sample(m)) taken++;
         pending_meas.push_back(m);
         made++;
      end
   endtask

   task automatic drain();
      int waited;
      waited = 0;
      while ((pending_meas.size() != 0 || req_valid || expected_summaries.size() != 0)
             && waited < 100000) begin
         @(posedge clock);
         waited++;
      end
   endtask

   task automatic write_reg(input pws_pkg::csr_reg_type idx, input logic [23:0] val);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      if (idx == pws_pkg::REG_TICK_LIMIT) begin
         cfg_max_ticks = val;
      end else begin
         cfg_ns = val[3:0];
      end
   endtask

   // summaries trail their closing beat; partial windows leave nothing to wait on
   task automatic set_config(input logic [23:0] max_t, input logic [3:0] ns);
      drain();
      repeat (20) @(posedge clock);
      write_reg(pws_pkg::REG_TICK_LIMIT, max_t);
      write_reg(pws_pkg::REG_NS_PER_TICK, {20'($urandom), ns});
      settings_used++;
   endtask

   always @(posedge clock) begin : sender
      meas_type nxt;
      if (reset) begin
         req_valid  <= 1'b0;
         burst_left <= 0;
         gap_left   <= 0;
      end else begin
         if (req_valid && !req_stall) begin
            account_measurement(on_bus);
            beats_sent++;
         end
         if (!req_valid || !req_stall) begin
            if (gap_left != 0) begin
               gap_left  <= gap_left - 1;
               req_valid <= 1'b0;
            end else if (pending_meas.size() != 0) begin
               nxt = pending_meas.pop_front();
               on_bus    <= nxt;
               req_valid <= 1'b1;
               if (burst_left <= 1) begin
                  burst_left <= $urandom_range(1, 48);
                  gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
               end else begin
                  burst_left <= burst_left - 1;
               end
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin : receiver
      summary_type want;
      if (reset) begin
         rsp_stall   <= 1'b0;
         stall_left  <= 0;
         stall_style <= FLOW;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_summaries.size() == 0) begin
               errors++;
               if (errors <= 40)
                  $display("%0t: unexpected summary beat, expected none actual number %0d",
                           $time, rsp_summary_number);
            end else begin
               want = expected_summaries.pop_front();
               compare("summary_number", want.number, rsp_summary_number);
               compare("avg_ns", want.avg, rsp_avg_ns);
               compare("min_ns", want.lo, rsp_min_ns);
               compare("max_ns", want.hi, rsp_max_ns);
               compare("p2p_ns", want.spread, rsp_p2p_ns);
               summaries_checked++;
            end
         end
         if (stall_left == 0) begin
            stall_style <= stall_style_type'($urandom_range(0, 3));
            stall_left  <= $urandom_range(20, 200);
         end else begin
            stall_left <= stall_left - 1;
         end
         case (stall_style)
            FLOW:     rsp_stall <= 1'b0;
            LIGHT:    rsp_stall <= ($urandom_range(0, 3) == 0);
            HEAVY:    rsp_stall <= ($urandom_range(0, 3) != 0);
            PERIODIC: rsp_stall <= stall_left[2];
            default:  rsp_stall <= 1'b0;
         endcase
      end
   end

   initial begin : stimulus
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // reset setting: limit edges, channel priority, ignored beats
      pending_meas.push_back(beat(1'b1, 32'd0, 1'b0, 32'd0));
      pending_meas.push_back(beat(1'b1, 32'd624999, 1'b0, 32'd0));
      pending_meas.push_back(beat(1'b1, 32'd625000, 1'b1, 32'd624999));
      pending_meas.push_back(beat(1'b1, 32'd100, 1'b1, 32'd200));
      pending_meas.push_back(beat(1'b1, 32'hFFFFFFFF, 1'b1, 32'd625000));
      pending_meas.push_back(beat(1'b0, 32'd0, 1'b0, 32'd0));
      pending_meas.push_back(beat(1'b0, 32'd0, 1'b1, 32'd0));
      pending_meas.push_back(beat(1'b0, 32'd0, 1'b1, 32'd1));
      pending_meas.push_back(beat(1'b0, 32'd5, 1'b1, 32'd7));
      pending_meas.push_back(beat(1'b1, 32'd12345, 1'b0, 32'd3));
      pending_meas.push_back(beat(1'b1, 32'd1, 1'b1, 32'd2));
      pending_meas.push_back(beat(1'b0, 32'd9, 1'b1, 32'd624999));
      load_random(130, 400);

      // widest limit, largest scale: saturation both ways
      set_config(24'hFFFFFF, 4'd15);
      pending_meas.push_back(beat(1'b1, 32'h00FFFFFE, 1'b0, 32'd0));
      pending_meas.push_back(beat(1'b0, 32'd0, 1'b1, 32'h00FFFFFE));
      pending_meas.push_back(beat(1'b1, 32'h00FFFFFF, 1'b0, 32'd0));
      load_random(130, 400);

      set_config(24'd1, 4'd1);
      load_random(100, 400);

      // zero limit: nothing is taken
      set_config(24'd0, 4'd5);
      load_random(1000, 30);

      set_config(24'($urandom_range(1, 24'hFFFFFF)), 4'd0);
      load_random(130, 400);

      // just below and just above the saturation point at scale 9
      set_config(24'hFFFFFF, 4'd9);
      pending_meas.push_back(beat(1'b1, 32'd14913080, 1'b0, 32'd0));
      pending_meas.push_back(beat(1'b1, 32'd14913081, 1'b0, 32'd0));
      pending_meas.push_back(beat(1'b0, 32'd0, 1'b1, 32'd14913080));
      pending_meas.push_back(beat(1'b0, 32'd0, 1'b1, 32'd14913081));
      load_random(130, 400);

      set_config(24'($urandom_range(1, 24'hFFFFFF)), 4'($urandom_range(10, 15)));
      load_random(130, 400);

      set_config(24'($urandom_range(1, 4000)), 4'($urandom_range(1, 8)));
      load_random(100, 400);

      set_config(24'd625000, 4'd8);
      load_random(65, 400);

      drain();
      repeat (30) @(posedge clock);
      if (expected_summaries.size() != 0) begin
         errors++;
         $display("%0t: %0d summaries expected but never seen", $time,
                  expected_summaries.size());
      end
      $display("Run covered %0d measurement beats, %0d samples, %0d window summaries checked",
               beats_sent, samples_taken, summaries_checked);
      $display("across %0d register settings incl. zero limit, zero scale and saturation",
               settings_used + 1);
      if (errors == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

   initial begin : watchdog
      #400000;
      $display("FAILURE");
      $finish;
   end

endmodule
